// ===== sv/bvas_pkg.sv =====
// ----------------------------------------------------------------------------
// bvas_pkg
// shared types and constants of the bounding-box volume / aspect block
// ----------------------------------------------------------------------------
package bvas_pkg;

    // parameter defaults
    localparam int COORD_BITS_DEF = 20;
    localparam int COUNT_BITS_DEF = 16;

    // result field widths
    localparam int VOL_W   = 44;
    localparam int RATIO_W = 30;
    localparam int SEV_W   = 17;
    localparam int TOTAL_W = 16;
    localparam int THR_W   = 20;

    // fixed-point and limits
    localparam int FRAC_BITS     = 16;
    localparam int SEV_SHIFT     = 32;
    localparam int VOL_SPLIT     = 22;
    localparam int MIN_VOL_PTS   = 4;
    localparam int MIN_RATIO_PTS = 2;

    localparam logic [VOL_W-1:0]   VOL_MAX   = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [SEV_W-1:0]   ONE_Q16   = SEV_W'(65536);
    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(65);

    // configuration port
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int REG_IDX_W    = APB_AW - 2;
    localparam int REG_THINNESS = 0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXT,
        S_MXY,
        S_MPL,
        S_MPH,
        S_ACCV,
        S_VOL,
        S_DIV,
        S_RATIO,
        S_MVL,
        S_MVH,
        S_ACCS,
        S_SEV
    } t_state;

    typedef enum logic [2:0] {
        MUL_XY,
        MUL_PL,
        MUL_PH,
        MUL_VL,
        MUL_VH
    } t_mul_op;

    typedef struct packed {
        logic    pt_ld;
        logic    ext_ld;
        logic    mm_ld;
        logic    den_ld;
        logic    mul_en;
        t_mul_op mul_op;
        logic    acc_ld;
        logic    acc_add;
        logic    acc_sev;
        logic    vol_ld;
        logic    div_init;
        logic    div_step;
        logic    ratio_ld;
        logic    out_ld;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

// ===== sv/bvas_if.sv =====
// ----------------------------------------------------------------------------
// bvas_if
// point and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface bvas_pt_if #(
    parameter int COORD_BITS = bvas_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
    logic                         last_point;

    modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface

interface bvas_res_if;
    logic                         valid;
    logic                         ready;
    logic [bvas_pkg::VOL_W-1:0]   box_volume;
    logic [bvas_pkg::RATIO_W-1:0] extent_ratio;
    logic [bvas_pkg::SEV_W-1:0]   severity;
    logic [bvas_pkg::TOTAL_W-1:0] point_total;

    modport source (output valid, box_volume, extent_ratio, severity, point_total,
                    input ready);
    modport sink   (input valid, box_volume, extent_ratio, severity, point_total,
                    output ready);
endinterface

// ===== sv/bvas_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvas_ctrl
// sequencer: point intake, then volume, divide and severity steps
// ----------------------------------------------------------------------------
module bvas_ctrl #(
    parameter int COORD_BITS = bvas_pkg::COORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  bvas_pkg::t_stat i_stat,
    output bvas_pkg::t_cmd  o_cmd
);
    import bvas_pkg::*;

    localparam int DIV_W = COORD_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               accept;
    logic               slot_free;

    assign accept    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && i_stat.last) n_state = S_EXT;
            S_EXT:   n_state = S_MXY;
            S_MXY:   n_state = S_MPL;
            S_MPL:   n_state = S_MPH;
            S_MPH:   n_state = S_ACCV;
            S_ACCV:  n_state = S_VOL;
            S_VOL:   n_state = S_DIV;
            S_DIV:   if (r_cnt == '0) n_state = S_RATIO;
            S_RATIO: n_state = S_MVL;
            S_MVL:   n_state = S_MVH;
            S_MVH:   n_state = S_ACCS;
            S_ACCS:  n_state = S_SEV;
            S_SEV:   if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = MUL_XY;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.pt_ld = i_in_valid;
            end
            S_EXT:   o_cmd.ext_ld = 1'b1;
            S_MXY: begin
                o_cmd.mm_ld  = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_XY;
            end
            S_MPL: begin
                o_cmd.den_ld = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_PL;
            end
            S_MPH: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_PH;
                o_cmd.acc_ld = 1'b1;
            end
            S_ACCV:  o_cmd.acc_add = 1'b1;
            S_VOL: begin
                o_cmd.vol_ld   = 1'b1;
                o_cmd.div_init = 1'b1;
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_RATIO: o_cmd.ratio_ld = 1'b1;
            S_MVL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_VL;
            end
            S_MVH: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_VH;
                o_cmd.acc_ld = 1'b1;
            end
            S_ACCS: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.acc_sev = 1'b1;
            end
            S_SEV:   o_cmd.out_ld = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_state == S_VOL) begin
            n_cnt = CNT_W'(DIV_W - 1);
        end else if (r_state == S_DIV) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_SEV && slot_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/bvas_dp.sv =====
// ----------------------------------------------------------------------------
// bvas_dp
// bounds, count, shared multiplier, accumulator, serial divider, result word
// ----------------------------------------------------------------------------
module bvas_dp #(
    parameter int COORD_BITS = bvas_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = bvas_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bvas_pkg::t_cmd                i_cmd,
    output bvas_pkg::t_stat               o_stat,
    input  logic signed [COORD_BITS-1:0]  i_x_coord,
    input  logic signed [COORD_BITS-1:0]  i_y_coord,
    input  logic signed [COORD_BITS-1:0]  i_z_coord,
    input  logic                          i_last_point,
    input  logic [bvas_pkg::THR_W-1:0]    i_thr,
    output logic [bvas_pkg::VOL_W-1:0]    o_box_volume,
    output logic [bvas_pkg::RATIO_W-1:0]  o_extent_ratio,
    output logic [bvas_pkg::SEV_W-1:0]    o_severity,
    output logic [bvas_pkg::TOTAL_W-1:0]  o_point_total
);
    import bvas_pkg::*;

    localparam int EXT_W = COORD_BITS;
    localparam int P_W   = 2 * EXT_W;
    localparam int MA    = (EXT_W > VOL_SPLIT) ? EXT_W : VOL_SPLIT;
    localparam int MB    = (EXT_W > RATIO_W) ? EXT_W : RATIO_W;
    localparam int ACC_W = (3 * EXT_W > VOL_W + RATIO_W) ? 3 * EXT_W : VOL_W + RATIO_W;
    localparam int DIV_W = EXT_W + FRAC_BITS;
    localparam int QW    = (DIV_W > RATIO_W) ? DIV_W : RATIO_W;
    localparam int CW    = (EXT_W > THR_W) ? EXT_W : THR_W;
    localparam int TW    = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

    // bounds and count
    logic signed [COORD_BITS-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y, r_lo_z, r_hi_z;
    logic [COUNT_BITS-1:0]        r_pts;
    logic [COUNT_BITS-1:0]        cnt_inc;
    logic [TW-1:0]                cnt_ext;
    logic                         first;
    logic                         r_vol_en, r_ratio_ok, r_div_en;
    logic [TOTAL_W-1:0]           r_total;

    // extents
    logic [EXT_W-1:0] r_dx, r_dy, r_dz, r_mx, r_mn;
    logic [EXT_W-1:0] mx_c, mn_c;

    // multiplier and accumulator
    logic [MA-1:0]      mul_a;
    logic [MB-1:0]      mul_b;
    logic [MA+MB-1:0]   mul_out;
    logic [MA+MB-1:0]   r_prod;
    logic [P_W-1:0]     r_p;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   acc_shr;
    logic [ACC_W-1:0]   sev_shr;
    logic [VOL_W-1:0]   r_vol;
    logic [RATIO_W-1:0] r_ratio;

    // divider
    logic [EXT_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [EXT_W:0]   rem_sh;
    logic             q_bit;
    logic [EXT_W-1:0] rem_nx;
    logic [QW-1:0]    quo_ext;

    // result word
    logic [VOL_W-1:0]   r_o_vol;
    logic [RATIO_W-1:0] r_o_ratio;
    logic [SEV_W-1:0]   r_o_sev;
    logic [TOTAL_W-1:0] r_o_total;

    assign o_stat.last = i_last_point;

    assign first   = (r_pts == '0);
    assign cnt_inc = (r_pts == '1) ? r_pts : r_pts + COUNT_BITS'(1);
    assign cnt_ext = TW'(cnt_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts <= '0;
        end else if (i_cmd.pt_ld) begin
            r_pts <= i_last_point ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_ld) begin
            if (first || i_x_coord < r_lo_x) r_lo_x <= i_x_coord;
            if (first || i_x_coord > r_hi_x) r_hi_x <= i_x_coord;
            if (first || i_y_coord < r_lo_y) r_lo_y <= i_y_coord;
            if (first || i_y_coord > r_hi_y) r_hi_y <= i_y_coord;
            if (first || i_z_coord < r_lo_z) r_lo_z <= i_z_coord;
            if (first || i_z_coord > r_hi_z) r_hi_z <= i_z_coord;
            if (i_last_point) begin
                r_vol_en   <= (cnt_inc >= COUNT_BITS'(MIN_VOL_PTS));
                r_ratio_ok <= (cnt_inc >= COUNT_BITS'(MIN_RATIO_PTS));
                r_total    <= (cnt_ext > TW'(TOTAL_MAX)) ? TOTAL_MAX : cnt_ext[TOTAL_W-1:0];
            end
        end
    end

    // extents are never negative, so the low bits of the difference suffice
    always_ff @(posedge i_clk) begin
        if (i_cmd.ext_ld) begin
            r_dx <= EXT_W'(unsigned'(r_hi_x - r_lo_x));
            r_dy <= EXT_W'(unsigned'(r_hi_y - r_lo_y));
            r_dz <= EXT_W'(unsigned'(r_hi_z - r_lo_z));
        end
    end

    always_comb begin
        mx_c = r_dx;
        if (r_dy > mx_c) mx_c = r_dy;
        if (r_dz > mx_c) mx_c = r_dz;
        mn_c = r_dx;
        if (r_dy < mn_c) mn_c = r_dy;
        if (r_dz < mn_c) mn_c = r_dz;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mm_ld) begin
            r_mx <= mx_c;
            r_mn <= mn_c;
        end
        if (i_cmd.den_ld) begin
            r_div_en <= r_ratio_ok && (CW'(r_mn) > CW'(i_thr));
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = MA'(r_dx);
        mul_b = MB'(r_dy);
        case (i_cmd.mul_op)
            MUL_XY: begin
                mul_a = MA'(r_dx);
                mul_b = MB'(r_dy);
            end
            MUL_PL: begin
                mul_a = MA'(r_p[EXT_W-1:0]);
                mul_b = MB'(r_dz);
            end
            MUL_PH: begin
                mul_a = MA'(r_p[P_W-1:EXT_W]);
                mul_b = MB'(r_dz);
            end
            MUL_VL: begin
                mul_a = MA'(r_vol[VOL_SPLIT-1:0]);
                mul_b = MB'(r_ratio);
            end
            MUL_VH: begin
                mul_a = MA'(r_vol[VOL_W-1:VOL_SPLIT]);
                mul_b = MB'(r_ratio);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out = (MA+MB)'(mul_a) * (MA+MB)'(mul_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_out;
            if (i_cmd.mul_op == MUL_XY) begin
                r_p <= mul_out[P_W-1:0];
            end
        end
    end

    // low partial product first, high one added shifted by its split point
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_ld) begin
            r_acc <= ACC_W'(r_prod);
        end else if (i_cmd.acc_add) begin
            if (i_cmd.acc_sev) begin
                r_acc <= r_acc + (ACC_W'(r_prod) << VOL_SPLIT);
            end else begin
                r_acc <= r_acc + (ACC_W'(r_prod) << EXT_W);
            end
        end
    end

    assign acc_shr = r_acc >> FRAC_BITS;
    assign sev_shr = r_acc >> SEV_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_cmd.vol_ld) begin
            if (!r_vol_en) begin
                r_vol <= '0;
            end else if (acc_shr > ACC_W'(VOL_MAX)) begin
                r_vol <= VOL_MAX;
            end else begin
                r_vol <= acc_shr[VOL_W-1:0];
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_mn});
    assign rem_nx = q_bit ? EXT_W'(rem_sh - {1'b0, r_mn}) : rem_sh[EXT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= {r_mx, {FRAC_BITS{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nx;
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
        end
    end

    assign quo_ext = QW'(r_quo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ratio_ld) begin
            if (!r_div_en) begin
                r_ratio <= RATIO_W'(ONE_Q16);
            end else if (quo_ext > QW'(RATIO_MAX)) begin
                r_ratio <= RATIO_MAX;
            end else begin
                r_ratio <= quo_ext[RATIO_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_o_vol   <= r_vol;
            r_o_ratio <= r_ratio;
            r_o_sev   <= (sev_shr > ACC_W'(ONE_Q16)) ? ONE_Q16 : sev_shr[SEV_W-1:0];
            r_o_total <= r_total;
        end
    end

    assign o_box_volume   = r_o_vol;
    assign o_extent_ratio = r_o_ratio;
    assign o_severity     = r_o_sev;
    assign o_point_total  = r_o_total;

endmodule

// ===== sv/box_volume_aspect_severity_core.sv =====
// ----------------------------------------------------------------------------
// box_volume_aspect_severity_core
// axis-aligned bounding box of a point cloud: volume, aspect ratio, severity
//
//   channel   dir   kind        word
//   i_pt      in    valid/rdy   x, y, z coordinate and last-point flag
//   o_res     out   valid/rdy   volume, aspect ratio, severity, point total
//   apb       in    apb write   thinness threshold at byte address 0
//
// a point is taken every cycle while the block is collecting; the word with
// the last-point flag starts the result sequence, which holds off i_pt through
// the extent, multiply, restoring-divide and severity steps, and for as long as
// the previous result still sits unread in o_res.
// the output register frees i_pt while a result waits to be taken.
// synchronous active-low reset clears the count, sequencer and valid flag.
// ----------------------------------------------------------------------------
module box_volume_aspect_severity_core #(
    parameter int COORD_BITS = bvas_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = bvas_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bvas_pt_if.sink                       i_pt,
    bvas_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bvas_pkg::APB_AW-1:0]   paddr,
    input  logic [bvas_pkg::APB_DW-1:0]   pwdata,
    output logic [bvas_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bvas_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic [THR_W-1:0] r_thr;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1:2] == REG_IDX_W'(REG_THINNESS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DW'(r_thr) : '0;

    bvas_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .o_in_ready  (i_pt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bvas_dp #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_x_coord      (i_pt.x_coord),
        .i_y_coord      (i_pt.y_coord),
        .i_z_coord      (i_pt.z_coord),
        .i_last_point   (i_pt.last_point),
        .i_thr          (r_thr),
        .o_box_volume   (o_res.box_volume),
        .o_extent_ratio (o_res.extent_ratio),
        .o_severity     (o_res.severity),
        .o_point_total  (o_res.point_total)
    );

endmodule

// ===== sim/box_volume_aspect_severity_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_volume_aspect_severity_core_tb
// self-checking bench for the bounding-box volume / aspect / severity core
//
// point words are fed from a queue by a clocked driver with random gaps, and
// result words are taken by a receiver with random stalls. a shadow
// computation of box bounds, volume, aspect ratio and severity runs on every
// accepted point and its results are compared with each result word. the
// thinness threshold is rewritten over apb between phases: 0, all ones,
// random values and the reset value.
// ----------------------------------------------------------------------------
module box_volume_aspect_severity_core_tb;
    import bvas_pkg::*;

    localparam int CW            = COORD_BITS_DEF;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 10;
    localparam logic [APB_AW-1:0] THR_ADDR = APB_AW'(4 * REG_THINNESS);

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
    } t_point;

    typedef struct packed {
        logic [VOL_W-1:0]   vol;
        logic [RATIO_W-1:0] ratio;
        logic [SEV_W-1:0]   sev;
        logic [TOTAL_W-1:0] total;
    } t_box_result;

    typedef enum {
        CLOUD_FULL,
        CLOUD_SPREAD,
        CLOUD_THIN,
        CLOUD_EDGE
    } t_cloud_shape;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bvas_pt_if  pt_if ();
    bvas_res_if res_if ();

    box_volume_aspect_severity_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus and expectations
    t_point      point_queue[$];
    t_box_result expected_boxes[$];
    t_box_result want_box;

    // shadow state of the block
    t_coord             lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic [TOTAL_W-1:0] cloud_count;
    logic [THR_W-1:0]   thinness;

    int   pts_sent = 0;
    int   pts_taken = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   settings_used = 1;
    logic pt_taken = 1'b0;
    logic res_taken = 1'b0;
    int   pt_gap = 0;
    int   pt_burst = 0;
    int   res_stall = 0;
    int   res_burst = 0;
    bit   res_held = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(4, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // expected result of one accepted point word
    task automatic absorb_point(input t_coord x, input t_coord y, input t_coord z,
                                input logic last);
        logic [63:0]  dx, dy, dz, top, bottom, ratio64;
        logic [95:0]  vol_wide;
        logic [79:0]  sev_wide;
        t_box_result  r;
        if (cloud_count == 0 || x < lo_x) lo_x = x;
        if (cloud_count == 0 || x > hi_x) hi_x = x;
        if (cloud_count == 0 || y < lo_y) lo_y = y;
        if (cloud_count == 0 || y > hi_y) hi_y = y;
        if (cloud_count == 0 || z < lo_z) lo_z = z;
        if (cloud_count == 0 || z > hi_z) hi_z = z;
        if (cloud_count != '1) cloud_count++;
        if (last) begin
            dx = 64'(longint'(hi_x) - longint'(lo_x));
            dy = 64'(longint'(hi_y) - longint'(lo_y));
            dz = 64'(longint'(hi_z) - longint'(lo_z));
            vol_wide = (96'(dx) * 96'(dy) * 96'(dz)) >> FRAC_BITS;
            if (cloud_count < MIN_VOL_PTS)
                r.vol = '0;
            else if (vol_wide > 96'(VOL_MAX))
                r.vol = VOL_MAX;
            else
                r.vol = vol_wide[VOL_W-1:0];
            top = dx;
            if (dy > top) top = dy;
            if (dz > top) top = dz;
            bottom = dx;
            if (dy < bottom) bottom = dy;
            if (dz < bottom) bottom = dz;
            ratio64 = 64'd65536;
            if (cloud_count >= MIN_RATIO_PTS && bottom > 64'(thinness)) begin
                ratio64 = (top << FRAC_BITS) / bottom;
                if (ratio64 > 64'(RATIO_MAX)) ratio64 = 64'(RATIO_MAX);
            end
            r.ratio = ratio64[RATIO_W-1:0];
            sev_wide = (80'(r.vol) * 80'(r.ratio)) >> SEV_SHIFT;
            r.sev = (sev_wide > 80'(ONE_Q16)) ? ONE_Q16 : sev_wide[SEV_W-1:0];
            r.total = cloud_count;
            expected_boxes.insert(expected_boxes.size(), r);
            cloud_count = '0;
        end
    endtask

    // point driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid      <= 1'b0;
            pt_if.x_coord    <= '0;
            pt_if.y_coord    <= '0;
            pt_if.z_coord    <= '0;
            pt_if.last_point <= 1'b0;
        end else if (pt_if.valid && !pt_taken) begin
            // word still waiting for ready
        end else if (pt_gap > 0) begin
            pt_if.valid <= 1'b0;
            pt_gap = pt_gap - 1;
        end else if (point_queue.size() > 0) begin
            pt_if.valid      <= 1'b1;
            pt_if.x_coord    <= point_queue[0].x;
            pt_if.y_coord    <= point_queue[0].y;
            pt_if.z_coord    <= point_queue[0].z;
            pt_if.last_point <= point_queue[0].last;
            void'(point_queue.pop_front());
            pts_sent++;
            pt_gap = draw_wait(pt_burst);
        end else begin
            pt_if.valid <= 1'b0;
        end
    end

    // result receiver: a stall is drawn for each new result word
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_taken) res_held = 1'b0;
            if (res_if.valid && !res_held) begin
                res_stall = draw_wait(res_burst);
                res_held  = 1'b1;
            end
            if (res_stall > 0) begin
                res_if.ready <= 1'b0;
                res_stall = res_stall - 1;
            end else if (!res_if.valid) begin
                res_if.ready <= ($urandom_range(0, 3) != 0);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        pt_taken  <= i_rst_n && pt_if.valid && pt_if.ready;
        res_taken <= i_rst_n && res_if.valid && res_if.ready;
        if (!i_rst_n) begin
            cloud_count = '0;
            thinness    = THR_RESET;
        end else begin
            if (psel && penable && pwrite && pready && paddr == THR_ADDR)
                thinness = pwdata[THR_W-1:0];
            if (pt_if.valid && pt_if.ready) begin
                absorb_point(pt_if.x_coord, pt_if.y_coord, pt_if.z_coord,
                             pt_if.last_point);
                pts_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (expected_boxes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t ns: result word with none expected: vol %0d ratio %0d",
                                 $time, res_if.box_volume, res_if.extent_ratio);
                end else begin
                    want_box = expected_boxes.pop_front();
                    if (want_box.vol != res_if.box_volume ||
                        want_box.ratio != res_if.extent_ratio ||
                        want_box.sev != res_if.severity ||
                        want_box.total != res_if.point_total) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t ns: exp/got vol %0d/%0d ratio %0d/%0d",
                                      " sev %0d/%0d total %0d/%0d"}, $time,
                                     want_box.vol, res_if.box_volume,
                                     want_box.ratio, res_if.extent_ratio,
                                     want_box.sev, res_if.severity,
                                     want_box.total, res_if.point_total);
                    end
                end
            end
        end
    end

    task automatic queue_point(input int x, input int y, input int z,
                               input logic last);
        t_point p;
        p.x    = t_coord'(x);
        p.y    = t_coord'(y);
        p.z    = t_coord'(z);
        p.last = last;
        point_queue.insert(point_queue.size(), p);
    endtask

    task automatic queue_cloud(input int n, input t_cloud_shape shape);
        t_coord      base[3];
        int unsigned reach[3];
        t_coord      c[3];
        int          thin_axis;
        thin_axis = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++) begin
            base[a] = CW'($urandom);
            if (shape == CLOUD_THIN && a == thin_axis)
                reach[a] = $urandom_range(0, 160);
            else
                reach[a] = 1 << $urandom_range(0, CW - 1);
        end
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < 3; a++) begin
                case (shape)
                    CLOUD_FULL: begin
                        c[a] = CW'($urandom);
                    end
                    CLOUD_EDGE: begin
                        case ($urandom_range(0, 5))
                            0: c[a] = {1'b1, {(CW-1){1'b0}}};
                            1: c[a] = {1'b0, {(CW-1){1'b1}}};
                            2: c[a] = '0;
                            3: c[a] = '1;
                            4: c[a] = t_coord'(1);
                            default: c[a] = CW'($urandom);
                        endcase
                    end
                    default: begin
                        c[a] = base[a] + CW'($urandom_range(0, reach[a]));
                    end
                endcase
            end
            queue_point(int'(c[0]), int'(c[1]), int'(c[2]), i == n - 1);
        end
    endtask

    task automatic wait_drained();
        while (point_queue.size() != 0 || pts_sent != pts_taken ||
               expected_boxes.size() != 0)
            @(negedge i_clk);
    endtask

    // only while idle: every result back and the sequencer settled
    task automatic write_thinness(input logic [THR_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THR_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_random_clouds(input int items);
        int queued;
        int n;
        int pick;
        t_cloud_shape shape;
        queued = 0;
        while (queued < items) begin
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(9, 24);
            else
                n = $urandom_range(1, 8);
            pick = $urandom_range(0, 19);
            if (pick < 8)
                shape = CLOUD_SPREAD;
            else if (pick < 13)
                shape = CLOUD_THIN;
            else if (pick < 17)
                shape = CLOUD_FULL;
            else
                shape = CLOUD_EDGE;
            queue_cloud(n, shape);
            queued += n;
            // now and then the sender holds until the block has drained
            if ($urandom_range(0, 11) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-point cloud
        queue_point(524287, -524288, 0, 1'b1);
        // two opposite corners: no volume, ratio one
        queue_point(-524288, -524288, -524288, 1'b0);
        queue_point(524287, 524287, 524287, 1'b1);
        // three points: ratio but still no volume
        queue_point(0, 0, 0, 1'b0);
        queue_point(100, 200, 300, 1'b0);
        queue_point(50, 50, 50, 1'b1);
        // smallest extent on the threshold, then just above it
        queue_point(0, 0, 0, 1'b0);
        queue_point(65, 1000, 2000, 1'b0);
        queue_point(10, 10, 10, 1'b0);
        queue_point(20, 20, 20, 1'b1);
        queue_point(0, 0, 0, 1'b0);
        queue_point(66, 1000, 2000, 1'b0);
        queue_point(10, 10, 10, 1'b0);
        queue_point(20, 20, 20, 1'b1);
        // full-range box, severity capped
        queue_point(-524288, -524288, -524288, 1'b0);
        queue_point(524287, 524287, 524287, 1'b0);
        queue_point(0, 0, 0, 1'b0);
        queue_point(1, -1, 5, 1'b1);

        write_thinness('0);
        // ratio saturation with a one-unit slab
        queue_point(0, -524288, -524288, 1'b0);
        queue_point(1, 524287, 524287, 1'b0);
        queue_point(0, 0, 0, 1'b0);
        queue_point(1, 0, 0, 1'b1);
        // zero extent does not exceed a zero threshold
        queue_point(5, 5, 5, 1'b0);
        queue_point(5, 5, 5, 1'b1);
        queue_random_clouds(80);

        write_thinness('1);
        queue_random_clouds(80);
        write_thinness(THR_W'($urandom));
        queue_random_clouds(80);
        write_thinness(THR_W'($urandom_range(0, 300)));
        queue_random_clouds(80);

        write_thinness(THR_RESET);
        queue_random_clouds(80);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d points in %0d clouds over %0d threshold settings",
                 pts_taken, results_seen, settings_used);
        $display("%0d result mismatches", mismatches);
        if (mismatches == 0 && expected_boxes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timeout: %0d results still expected", expected_boxes.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
